// ----- hw/rtl/dtp_pkg.sv -----
// Shared types, character codes and unit scale tables for the duration text parser.
// Depends on nothing; imported by every module of the block.
package dtp_pkg;

    // Class of one text byte as seen by the front end.
    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_UNIT_D,
        CLS_UNIT_H,
        CLS_UNIT_M,
        CLS_UNIT_S,
        CLS_PLUS,
        CLS_MINUS,
        CLS_OTHER
    } byte_class_t;

    // Time units, in the order of their scale.
    typedef enum logic [2:0] {
        U_MS,
        U_SEC,
        U_MIN,
        U_HOUR,
        U_DAY
    } unit_t;

    localparam int NUM_UNITS = 5;

    // One classified word passed from the front end to the back end.
    typedef struct packed {
        byte_class_t cls;
        logic [3:0]  digit;
        logic        first;
        logic        last;
    } op_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_S     = 8'h73;

    localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    // Milliseconds in one of each unit.
    function automatic logic [26:0] unit_scale(unit_t u);
        logic [26:0] s;
        unique case (u)
            U_MS:    s = 27'd1;
            U_SEC:   s = 27'd1000;
            U_MIN:   s = 27'd60000;
            U_HOUR:  s = 27'd3600000;
            U_DAY:   s = 27'd86400000;
            default: s = '0;
        endcase
        return s;
    endfunction

    // A single decimal digit weighted by the scale of a unit.
    function automatic logic [30:0] digit_scaled(unit_t u, logic [3:0] d);
        return 31'(d) * 31'(unit_scale(u));
    endfunction

endpackage

// ----- hw/rtl/dtp_front.sv -----
// Front end of the duration text parser: classifies each text byte into a word.
// Depends on dtp_pkg.
module dtp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     char_byte,
    input  logic           is_final,
    input  logic           char_valid,
    input  logic           queue_full,
    output logic           push,
    output dtp_pkg::op_t   push_op
);
    import dtp_pkg::*;

    logic        first_reg;
    logic        first_next;
    byte_class_t cls;

    assign push = char_valid && !queue_full;

    // The next byte opens a new string once a final byte has been taken.
    always_comb
    begin
        first_next = first_reg;
        if (push)
        begin
            first_next = is_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else
        begin
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        unique case (char_byte) inside
            [CH_ZERO:CH_NINE]: cls = CLS_DIGIT;
            CH_D:              cls = CLS_UNIT_D;
            CH_H:              cls = CLS_UNIT_H;
            CH_M:              cls = CLS_UNIT_M;
            CH_S:              cls = CLS_UNIT_S;
            CH_PLUS:           cls = CLS_PLUS;
            CH_MINUS:          cls = CLS_MINUS;
            default:           cls = CLS_OTHER;
        endcase
    end

    assign push_op.cls   = cls;
    assign push_op.digit = char_byte[3:0];
    assign push_op.first = first_reg;
    assign push_op.last  = is_final;

endmodule

// ----- hw/rtl/dtp_queue.sv -----
// Two-entry queue of classified words between the front and back ends.
// Depends on dtp_pkg.
module dtp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dtp_pkg::op_t   push_op,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output dtp_pkg::op_t   head_op
);
    import dtp_pkg::*;

    op_t        entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_op   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- hw/rtl/dtp_back.sv -----
// Back end of the duration text parser: number and total accumulation, overflow
// checks and the result register. Depends on dtp_pkg.
module dtp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  dtp_pkg::op_t        head_op,
    output logic                pop,
    input  logic                result_stall,
    output logic                result_valid,
    output logic                ok,
    output logic signed [63:0]  duration_ms
);
    import dtp_pkg::*;

    // Parse state
    logic                 done_reg,       done_next;
    logic                 neg_reg,        neg_next;
    logic                 ds_reg,         ds_next;
    logic                 mp_reg,         mp_next;
    logic                 seen_reg,       seen_next;
    logic                 err_reg,        err_next;
    logic [63:0]          total_reg,      total_next;
    // The pending number times each unit scale, with a flag once it passes MAX_POS.
    logic [63:0]          prod_reg  [NUM_UNITS];
    logic [63:0]          prod_next [NUM_UNITS];
    logic [NUM_UNITS-1:0] big_reg,        big_next;

    // Result register
    logic                 res_valid_reg,  res_valid_next;
    logic                 res_ok_reg,     res_ok_next;
    logic                 res_neg_reg,    res_neg_next;
    logic [63:0]          res_mag_reg,    res_mag_next;

    logic                 out_free;
    logic                 lone;
    logic                 body;
    logic                 do_unit;
    logic                 do_digit;
    logic                 clear_base;
    logic                 do_fail;
    logic                 go_done;
    logic                 set_mp;
    unit_t                unit_sel;
    logic [64:0]          unit_sum;
    logic                 unit_bad;
    logic                 unit_fail;
    logic                 digit_fail;
    logic                 tail_fail;
    logic                 final_ok;
    logic [63:0]          base      [NUM_UNITS];
    logic [67:0]          prod_cand [NUM_UNITS];
    logic [NUM_UNITS-1:0] big_cand;

    assign out_free = !res_valid_reg || !result_stall;
    assign pop      = head_valid && (!head_op.last || out_free);

    // Decode what this word does to the parse state.
    always_comb
    begin
        do_unit    = 1'b0;
        unit_sel   = U_MS;
        do_digit   = 1'b0;
        clear_base = 1'b0;
        do_fail    = 1'b0;
        go_done    = 1'b0;
        set_mp     = 1'b0;
        lone = head_op.first && (head_op.cls == CLS_DIGIT) && (head_op.digit == 4'd0);
        body = pop && (head_op.first ? !(head_op.cls == CLS_PLUS || head_op.cls == CLS_MINUS)
                                     : !done_reg);
        if (body)
        begin
            if (mp_reg)
            begin
                // A held 'm' is settled by this byte: "ms" or minutes.
                do_unit = 1'b1;
                if (head_op.cls == CLS_UNIT_S)
                begin
                    unit_sel = U_MS;
                end
                else
                begin
                    unit_sel = U_MIN;
                    if (head_op.cls == CLS_DIGIT)
                    begin
                        do_digit   = 1'b1;
                        clear_base = 1'b1;
                    end
                    else
                    begin
                        go_done = 1'b1;
                    end
                end
            end
            else if (ds_reg)
            begin
                unique case (head_op.cls)
                    CLS_DIGIT:
                    begin
                        do_digit = 1'b1;
                    end
                    CLS_UNIT_D:
                    begin
                        do_unit  = 1'b1;
                        unit_sel = U_DAY;
                    end
                    CLS_UNIT_H:
                    begin
                        do_unit  = 1'b1;
                        unit_sel = U_HOUR;
                    end
                    CLS_UNIT_S:
                    begin
                        do_unit  = 1'b1;
                        unit_sel = U_SEC;
                    end
                    CLS_UNIT_M:
                    begin
                        set_mp = 1'b1;
                    end
                    default:
                    begin
                        do_fail = 1'b1;
                    end
                endcase
            end
            else if (head_op.cls == CLS_DIGIT)
            begin
                do_digit = 1'b1;
            end
            else
            begin
                go_done = 1'b1;
            end
        end
        // An 'm' on the final byte means minutes.
        if (set_mp && head_op.last)
        begin
            do_unit  = 1'b1;
            unit_sel = U_MIN;
        end
    end

    // Unit add: total plus the pending number at the chosen scale.
    assign unit_sum = {1'b0, total_reg} + {1'b0, prod_reg[unit_sel]};
    assign unit_bad = big_reg[unit_sel] || (unit_sum[64:63] != 2'b00);

    // Digit add for every unit scale at once: p * 10 + d * scale.
    always_comb
    begin
        for (int u = 0; u < NUM_UNITS; u++)
        begin
            base[u]      = clear_base ? 64'd0 : prod_reg[u];
            prod_cand[u] = 68'({base[u], 3'b000}) + 68'({base[u], 1'b0})
                         + 68'(digit_scaled(unit_t'(3'(u)), head_op.digit));
            big_cand[u]  = (!clear_base && big_reg[u]) || (prod_cand[u][67:63] != 5'd0);
        end
    end

    assign unit_fail  = do_unit && unit_bad;
    assign digit_fail = do_digit && !unit_fail && big_cand[U_MS];

    always_comb
    begin
        done_next  = done_reg;
        neg_next   = neg_reg;
        ds_next    = ds_reg;
        mp_next    = mp_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        total_next = total_reg;
        big_next   = big_reg;
        for (int u = 0; u < NUM_UNITS; u++)
        begin
            prod_next[u] = prod_reg[u];
        end

        if (pop && head_op.first && head_op.cls == CLS_MINUS)
        begin
            neg_next = 1'b1;
        end
        if (body && mp_reg)
        begin
            mp_next = 1'b0;
        end
        if (do_unit && !unit_fail)
        begin
            total_next = unit_sum[63:0];
            seen_next  = 1'b1;
            ds_next    = 1'b0;
            big_next   = '0;
            for (int u = 0; u < NUM_UNITS; u++)
            begin
                prod_next[u] = 64'd0;
            end
        end
        if (do_digit && !unit_fail && !digit_fail)
        begin
            ds_next  = 1'b1;
            big_next = big_cand;
            for (int u = 0; u < NUM_UNITS; u++)
            begin
                prod_next[u] = prod_cand[u][63:0];
            end
        end
        if (go_done)
        begin
            done_next = 1'b1;
        end
        if (set_mp && !head_op.last)
        begin
            mp_next = 1'b1;
        end
        if (do_fail || unit_fail || digit_fail)
        begin
            err_next  = 1'b1;
            done_next = 1'b1;
            ds_next   = 1'b0;
            mp_next   = 1'b0;
        end

        // A number left without a unit at the end of the string is an error, except a lone zero.
        tail_fail = pop && head_op.last && !err_next && ds_next && !lone;
        final_ok  = lone || (!err_next && !tail_fail && seen_next);

        res_valid_next = res_valid_reg && result_stall;
        res_ok_next    = res_ok_reg;
        res_neg_next   = res_neg_reg;
        res_mag_next   = res_mag_reg;

        if (pop && head_op.last)
        begin
            res_valid_next = 1'b1;
            res_ok_next    = final_ok;
            res_neg_next   = neg_next && !lone;
            res_mag_next   = (final_ok && !lone) ? total_next : 64'd0;
            // Start the next string from a clean state.
            done_next  = 1'b0;
            neg_next   = 1'b0;
            ds_next    = 1'b0;
            mp_next    = 1'b0;
            seen_next  = 1'b0;
            err_next   = 1'b0;
            total_next = 64'd0;
            big_next   = '0;
            for (int u = 0; u < NUM_UNITS; u++)
            begin
                prod_next[u] = 64'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            ds_reg        <= 1'b0;
            mp_reg        <= 1'b0;
            seen_reg      <= 1'b0;
            err_reg       <= 1'b0;
            total_reg     <= 64'd0;
            big_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int u = 0; u < NUM_UNITS; u++)
            begin
                prod_reg[u] <= 64'd0;
            end
        end
        else
        begin
            done_reg      <= done_next;
            neg_reg       <= neg_next;
            ds_reg        <= ds_next;
            mp_reg        <= mp_next;
            seen_reg      <= seen_next;
            err_reg       <= err_next;
            total_reg     <= total_next;
            big_reg       <= big_next;
            res_valid_reg <= res_valid_next;
            for (int u = 0; u < NUM_UNITS; u++)
            begin
                prod_reg[u] <= prod_next[u];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_ok_reg  <= res_ok_next;
        res_neg_reg <= res_neg_next;
        res_mag_reg <= res_mag_next;
    end

    assign result_valid = res_valid_reg;
    assign ok           = res_ok_reg;
    assign duration_ms  = res_neg_reg ? $signed(64'd0 - res_mag_reg) : $signed(res_mag_reg);

endmodule

// ----- hw/rtl/duration_text_to_ms_parser.sv -----
// Duration text parser: one text byte per word in, one result word per string out.
// Throughput: one byte per cycle, sustained, with no gap between strings, while the result side does not stall.
// Result path: with the result side free, the final byte of a string is classified
// combinationally and written into the word queue, and the back end then loads the
// result register from the queue head.
// Reset: rst_n is asynchronous and active low; it empties the queue and returns the
// parser to the start of a string with no result pending.
module duration_text_to_ms_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          char_byte,
    input  logic                is_final,
    input  logic                char_valid,
    output logic                char_stall,
    output logic                ok,
    output logic signed [63:0]  duration_ms,
    output logic                result_valid,
    input  logic                result_stall
);
    import dtp_pkg::*;

    // The front end turns each byte into a small classified word: digit, one of
    // the unit letters, a sign or anything else, together with whether it opens
    // or closes a string. It stalls only when the queue holds two words.
    logic queue_full;
    logic push;
    op_t  push_op;

    // The queue lets a stalled result register hold the back end without
    // stalling the text stream at once, and keeps the input stall registered.
    logic queue_not_empty;
    logic pop;
    op_t  head_op;

    dtp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_byte  (char_byte),
        .is_final   (is_final),
        .char_valid (char_valid),
        .queue_full (queue_full),
        .push       (push),
        .push_op    (push_op)
    );

    assign char_stall = queue_full;

    dtp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_op   (head_op)
    );

    // The back end keeps the running total and, for the number being read, its
    // value already scaled by every unit. A digit updates all five scaled copies
    // by a shift-and-add times ten, and a unit letter adds one of them to the
    // total, so no wide multiplier is needed. Overflow past the largest positive
    // 64-bit value is flagged per copy. A word that closes a string waits only
    // when the result register is still full and stalled.
    dtp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (queue_not_empty),
        .head_op      (head_op),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .ok           (ok),
        .duration_ms  (duration_ms)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the streaming duration text parser.
// Depends on dtp_pkg for the character codes and the signed range limit,
// and on the duration_text_to_ms_parser RTL as the block under test.
`timescale 1ns / 1ps

module testbench;

    import dtp_pkg::*;

    // Parser phases of the predictor. Any code other than the first two is
    // treated as the phase that ignores the rest of the string.
    localparam logic [2:0] PH_OPEN    = 3'd0;
    localparam logic [2:0] PH_NUMBERS = 3'd1;
    localparam logic [2:0] PH_IGNORE  = 3'd2;

    // Milliseconds in one of each unit.
    localparam logic [63:0] MS_PER_DAY  = 64'd86400000;
    localparam logic [63:0] MS_PER_HOUR = 64'd3600000;
    localparam logic [63:0] MS_PER_MIN  = 64'd60000;
    localparam logic [63:0] MS_PER_SEC  = 64'd1000;
    localparam logic [63:0] MS_PER_MS   = 64'd1;

    // Unit choices when text is generated.
    localparam int UNIT_DAY  = 0;
    localparam int UNIT_HOUR = 1;
    localparam int UNIT_MIN  = 2;
    localparam int UNIT_SEC  = 3;
    localparam int UNIT_MS   = 4;

    // Words taken per random idling phase, and the length of the long hold-off.
    localparam int PHASE_WORDS   = 160;
    localparam int HOLD_CYCLES   = 90;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic               ok;
        logic signed [63:0] ms;
    } duration_result_t;

    logic               clk;
    logic               rst_n;
    logic [7:0]         char_byte;
    logic               is_final;
    logic               char_valid;
    logic               char_stall;
    logic               ok;
    logic signed [63:0] duration_ms;
    logic               result_valid;
    logic               result_stall;

    // Predictor state, a private copy of what the parser should hold.
    logic [2:0]  dur_phase;
    logic        dur_negative;
    logic [63:0] dur_number;
    logic [63:0] dur_total;
    logic        dur_digits;
    logic        dur_min_pending;
    logic        dur_unit_seen;
    logic        dur_lone_zero;
    logic        dur_error;

    // Results that the parser still owes us, oldest first.
    duration_result_t expected_durations[$];

    // Text of the string that is about to be sent.
    logic [7:0] text_buf[$];

    int sender_idle_pct;
    int recv_stall_pct;
    int hold_off_left;

    int fail_count;
    int words_sent;
    int strings_sent;
    int results_checked;
    int results_parsed;

    duration_text_to_ms_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_byte    (char_byte),
        .is_final     (is_final),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .ok           (ok),
        .duration_ms  (duration_ms),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // 8 ns clock period.
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Returns the predictor to the start of a string.
    function automatic void dur_clear();
        dur_phase       = PH_OPEN;
        dur_negative    = 1'b0;
        dur_number      = '0;
        dur_total       = '0;
        dur_digits      = 1'b0;
        dur_min_pending = 1'b0;
        dur_unit_seen   = 1'b0;
        dur_lone_zero   = 1'b0;
        dur_error       = 1'b0;
    endfunction

    // A parse error: the rest of the string is ignored.
    function automatic void dur_abort();
        dur_error       = 1'b1;
        dur_phase       = PH_IGNORE;
        dur_digits      = 1'b0;
        dur_min_pending = 1'b0;
    endfunction

    // Closes the current number with a unit, flagging overflow of the total.
    function automatic void dur_add_unit(logic [63:0] scale);
        if (dur_number > (MAX_POS - dur_total) / scale)
        begin
            dur_abort();
            return;
        end
        dur_total     = dur_total + dur_number * scale;
        dur_unit_seen = 1'b1;
        dur_number    = '0;
        dur_digits    = 1'b0;
    endfunction

    function automatic void dur_add_digit(logic [7:0] c);
        logic [63:0] d;
        d = 64'(c) - 64'(CH_ZERO);
        if (dur_number > (MAX_POS - d) / 64'd10)
        begin
            dur_abort();
            return;
        end
        dur_number = dur_number * 64'd10 + d;
        dur_digits = 1'b1;
    endfunction

    // One byte in the body of the string, after any sign.
    function automatic void dur_body(logic [7:0] c);
        logic is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (dur_min_pending)
        begin
            dur_min_pending = 1'b0;
            if (c == CH_S)
            begin
                dur_add_unit(MS_PER_MS);
                return;
            end
            dur_add_unit(MS_PER_MIN);
            if (dur_error)
                return;
        end
        if (dur_digits)
        begin
            if (is_digit)
                dur_add_digit(c);
            else if (c == CH_D)
                dur_add_unit(MS_PER_DAY);
            else if (c == CH_H)
                dur_add_unit(MS_PER_HOUR);
            else if (c == CH_S)
                dur_add_unit(MS_PER_SEC);
            else if (c == CH_M)
                dur_min_pending = 1'b1;
            else
                dur_abort();
        end
        else
        begin
            if (is_digit)
                dur_add_digit(c);
            else
                dur_phase = PH_IGNORE;
        end
    endfunction

    // Takes one accepted word and queues the result it causes, if any.
    function automatic void predict_duration(logic [7:0] c, logic fin);
        duration_result_t res;
        if (dur_phase == PH_OPEN)
        begin
            dur_lone_zero = (c == CH_ZERO);
            dur_phase     = PH_NUMBERS;
            if (c == CH_MINUS)
                dur_negative = 1'b1;
            else if (c != CH_PLUS)
                dur_body(c);
        end
        else
        begin
            dur_lone_zero = 1'b0;
            if (dur_phase == PH_NUMBERS)
                dur_body(c);
        end

        if (!fin)
            return;

        if (!dur_error)
        begin
            if (dur_min_pending)
            begin
                dur_min_pending = 1'b0;
                dur_add_unit(MS_PER_MIN);
            end
            else if (dur_digits && !dur_lone_zero)
            begin
                dur_abort();
            end
        end
        if (dur_lone_zero)
        begin
            res.ok = 1'b1;
            res.ms = '0;
        end
        else
        begin
            res.ok = !dur_error && dur_unit_seen;
            res.ms = '0;
            if (res.ok)
                res.ms = dur_negative ? -$signed(dur_total) : $signed(dur_total);
        end
        expected_durations.push_back(res);
        dur_clear();
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one word, with random idle cycles in front of it. Called and
    // returning just after a falling edge, so each call makes at most one
    // assignment to char_valid per time step.
    task automatic send_word(input logic [7:0] c, input logic fin);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_byte  <= c;
        is_final   <= fin;
        char_valid <= 1'b1;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        predict_duration(c, fin);
        words_sent++;
        @(negedge clk);
    endtask

    // Sends the buffered text as one string, the last byte marked final.
    task automatic send_text();
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++)
            send_word(text_buf[i], i == n - 1);
        strings_sent++;
        text_buf.delete();
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic push_digits(input int len, input logic [7:0] lead);
        text_buf.push_back(lead);
        for (int i = 1; i < len; i++)
            text_buf.push_back(CH_ZERO + 8'($urandom_range(9, 0)));
    endtask

    task automatic push_unit(input int u);
        case (u)
            UNIT_DAY:  text_buf.push_back(CH_D);
            UNIT_HOUR: text_buf.push_back(CH_H);
            UNIT_MIN:  text_buf.push_back(CH_M);
            UNIT_SEC:  text_buf.push_back(CH_S);
            default:
            begin
                text_buf.push_back(CH_M);
                text_buf.push_back(CH_S);
            end
        endcase
    endtask

    // Mostly short numbers; now and then long ones that reach the overflow
    // limits of the number, the product or the total.
    task automatic push_number();
        int r;
        int len;
        r = $urandom_range(99, 0);
        if (r < 84)
            len = $urandom_range(4, 1);
        else if (r < 94)
            len = $urandom_range(11, 5);
        else
            len = $urandom_range(20, 12);
        push_digits(len, CH_ZERO + 8'($urandom_range(9, 0)));
    endtask

    // Builds one random string. Most are well formed with random content;
    // the rest are lone zeros, broken sequences and plain noise.
    task automatic build_random_text();
        int r;
        int parts;
        r = $urandom_range(99, 0);
        if (r < 10)
        begin
            repeat ($urandom_range(6, 1))
                text_buf.push_back(8'($urandom_range(255, 0)));
        end
        else if (r < 14)
        begin
            case ($urandom_range(3, 0))
                0:       push_str("0");
                1:       push_str("+0");
                2:       push_str("-0");
                default: push_str("00");
            endcase
        end
        else
        begin
            r = $urandom_range(99, 0);
            if (r < 15)
                text_buf.push_back(CH_PLUS);
            else if (r < 30)
                text_buf.push_back(CH_MINUS);
            parts = $urandom_range(4, 1);
            for (int p = 0; p < parts; p++)
            begin
                push_number();
                r = $urandom_range(99, 0);
                if (r < 4)
                    text_buf.push_back(8'($urandom_range(255, 0)));
                else if (!(p == parts - 1 && r < 9))
                    push_unit($urandom_range(UNIT_MS, UNIT_DAY));
            end
            // Trailing bytes after the last unit: junk that ends parsing,
            // sometimes followed by a further number with its unit.
            if ($urandom_range(99, 0) < 8)
            begin
                text_buf.push_back(8'($urandom_range(255, 0)));
                if ($urandom_range(1, 0) == 1)
                    push_str("3s");
            end
        end
    endtask

    // Stops offering words until every expected result has come, then lets
    // the pipeline settle.
    task automatic wait_for_results();
        char_valid <= 1'b0;
        while (expected_durations.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Stall driver. A long hold-off, once requested, is counted down here;
    // otherwise the receiver stalls at random at the current rate.
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            result_stall  <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end
        else
        begin
            result_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // Result checker: every accepted result word is compared with the oldest
    // expectation.
    always @(posedge clk)
    begin
        duration_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_durations.size() == 0)
            begin
                $error("result word with no expectation: ok=%0b duration_ms=%0d",
                       ok, duration_ms);
                fail_count++;
            end
            else
            begin
                want = expected_durations.pop_front();
                results_checked++;
                if (want.ok)
                    results_parsed++;
                if (ok !== want.ok)
                begin
                    $error("ok mismatch: expected %0b, actual %0b", want.ok, ok);
                    fail_count++;
                end
                if (duration_ms !== want.ms)
                begin
                    $error("duration_ms mismatch: expected %0d, actual %0d",
                           want.ms, duration_ms);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short directed strings: every unit, both signs, the lone zero, a
    // signed zero, a final minute, missing and unknown units, parsing that
    // stops at a non-digit, and the two extreme byte values.
    task automatic test_directed();
        push_str("0");    send_text();
        push_str("+0");   send_text();
        push_str("-5m");  send_text();
        push_str("7ms");  send_text();
        push_str("1d2h"); send_text();
        push_str("5x");   send_text();
        push_str("9");    send_text();
        push_str("4s-");  send_text();
        text_buf.push_back(8'h00); send_text();
        text_buf.push_back(8'hFF); send_text();
    endtask

    // Numbers at and beyond the signed limit: too many digits, a product too
    // large, and a total that runs over after two parts.
    task automatic test_overflow();
        push_digits(19, CH_NINE);
        push_unit(UNIT_MS);
        send_text();
        push_str("9223372036854775807ms");
        send_text();
        push_str("-106751991167d");
        send_text();
        push_str("106751991168d");
        send_text();
        push_digits(12, CH_NINE);
        push_unit(UNIT_HOUR);
        send_text();
        push_str("5000000000000000000ms");
        push_str("5000000000000000000ms");
        send_text();
        push_digits(20, CH_ZERO + 8'($urandom_range(9, 1)));
        push_unit(UNIT_SEC);
        send_text();
    endtask

    // Random strings under one idling pattern, until enough words are taken.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int start_words;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        start_words     = words_sent;
        while (words_sent - start_words < PHASE_WORDS)
        begin
            build_random_text();
            send_text();
        end
    endtask

    // The receiver holds off for a long stretch while short strings keep
    // coming, so the parser fills up and stalls its input.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_off_left   = HOLD_CYCLES;
        repeat (12)
        begin
            if ($urandom_range(1, 0) == 1)
                push_str("0");
            else
                push_str("12s");
            send_text();
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n           = 1'b0;
        char_byte       = '0;
        is_final        = 1'b0;
        char_valid      = 1'b0;
        result_stall    = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_off_left   = 0;
        fail_count      = 0;
        words_sent      = 0;
        strings_sent    = 0;
        results_checked = 0;
        results_parsed  = 0;
        dur_clear();

        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_overflow();
        wait_for_results();

        test_random_traffic(0, 0);
        test_random_traffic(54, 0);
        wait_for_results();
        test_random_traffic(0, 54);
        test_random_traffic(33, 33);

        test_backpressure();
        wait_for_results();

        $display("Sent %0d words in %0d strings with idling and a long hold-off;",
                 words_sent, strings_sent);
        $display("checked %0d results, %0d parsed and %0d rejected.",
                 results_checked, results_parsed, results_checked - results_parsed);
        if (fail_count == 0)
            $display("duration_text_to_ms_parser verification clean");
        else
            $display("duration_text_to_ms_parser verification failed");
        $finish;
    end

    // Watchdog: a stuck handshake ends the run here.
    initial
    begin
        #4000000;
        $display("duration_text_to_ms_parser verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dtp_pkg.sv
hw/rtl/dtp_front.sv
hw/rtl/dtp_queue.sv
hw/rtl/dtp_back.sv
hw/rtl/duration_text_to_ms_parser.sv
tb/sv/testbench.sv
